// ===== src/mask_centroid_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// mask centroid tracker assertion macros
// checks clocked on aclk, held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef MASK_CENTROID_TRACKER_TOP_MACROS_SVH
`define MASK_CENTROID_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define MCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// shared widths, constants, types and helpers of the mask centroid tracker
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int WIN_MAX    = 2048;

    localparam int CFG_W   = 12;
    localparam int CFG_XW  = CFG_W + 1;
    localparam int IDX_W   = 2;
    localparam int LABEL_W = 2;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int QW      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int COUNT_W = COL_W + ROW_W + 1;
    localparam int SUM_W   = COUNT_W - 1 + QW;
    localparam int STEP_W  = $clog2(QW);

    localparam int CENTRE_W   = 11;
    localparam int CENTRE_MAX = 2047;
    localparam int HALF_W     = $clog2(WIN_MAX / 2 + 1);
    localparam int WIN_W      = 12;
    localparam int PRED_W     = 13;
    localparam int PRED_XW    = PRED_W + 1;
    localparam int PRED_MAX   = 4095;
    localparam int PRED_MIN   = -4096;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [CFG_W-1:0] RST_WINDOW_SIZE  = 12'd96;

    localparam logic [LABEL_W-1:0] LABEL_FG      = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_PROB_FG = 2'd3;

    typedef struct packed {
        logic               frame_end;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
    } acc_out_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CFG_W-1:0] dim_limit(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_XW-1:0] maxv);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (CFG_XW'(v) > maxv) begin
            r = CFG_W'(maxv);
        end
        return r;
    endfunction

    function automatic logic [CENTRE_W-1:0] sat_centre(input logic [QW-1:0] q);
        logic [CENTRE_W-1:0] r;
        r = CENTRE_W'(q);
        if (q > QW'(CENTRE_MAX)) begin
            r = CENTRE_W'(CENTRE_MAX);
        end
        return r;
    endfunction

    function automatic logic signed [PRED_W-1:0] sat_pred(
        input logic signed [PRED_XW-1:0] v);
        logic signed [PRED_W-1:0] r;
        r = v[PRED_W-1:0];
        if (v > $signed(PRED_XW'(PRED_MAX))) begin
            r = $signed(PRED_W'(PRED_MAX));
        end else if (v < $signed(PRED_XW'(PRED_MIN))) begin
            r = $signed(PRED_W'(PRED_MIN));
        end
        return r;
    endfunction

endpackage

// ===== src/mct_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_accum
// raster position counters and foreground count and coordinate sums
// ----------------------------------------------------------------------------
module mct_accum (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pix_accept,
    input  logic [mct_pkg::LABEL_W-1:0]     pix_label,
    input  logic [mct_pkg::CFG_W-1:0]       frame_w,
    input  logic [mct_pkg::CFG_W-1:0]       frame_h,
    output mct_pkg::acc_out_t               acc_out
);

    logic [mct_pkg::COL_W-1:0]   col_reg, col_next;
    logic [mct_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [mct_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [mct_pkg::SUM_W-1:0]   csum_reg, csum_next;
    logic [mct_pkg::SUM_W-1:0]   rsum_reg, rsum_next;

    logic                        fg;
    logic                        last_col;
    logic                        last_row;
    logic [mct_pkg::COUNT_W-1:0] count_upd;
    logic [mct_pkg::SUM_W-1:0]   csum_upd;
    logic [mct_pkg::SUM_W-1:0]   rsum_upd;

    always_comb begin
        fg       = (pix_label == mct_pkg::LABEL_FG) || (pix_label == mct_pkg::LABEL_PROB_FG);
        last_col = !((mct_pkg::CFG_XW'(col_reg) + mct_pkg::CFG_XW'(1)) <
                     mct_pkg::CFG_XW'(frame_w));
        last_row = !((mct_pkg::CFG_XW'(row_reg) + mct_pkg::CFG_XW'(1)) <
                     mct_pkg::CFG_XW'(frame_h));

        count_upd = count_reg + mct_pkg::COUNT_W'(fg);
        csum_upd  = fg ? (csum_reg + mct_pkg::SUM_W'(col_reg)) : csum_reg;
        rsum_upd  = fg ? (rsum_reg + mct_pkg::SUM_W'(row_reg)) : rsum_reg;

        acc_out.frame_end = pix_accept && last_col && last_row;
        acc_out.count     = count_upd;
        acc_out.col_sum   = csum_upd;
        acc_out.row_sum   = rsum_upd;

        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        csum_next  = csum_reg;
        rsum_next  = rsum_reg;
        if (pix_accept) begin
            col_next = last_col ? '0 : (col_reg + mct_pkg::COL_W'(1));
            if (last_col) begin
                row_next = last_row ? '0 : (row_reg + mct_pkg::ROW_W'(1));
            end
            if (last_col && last_row) begin
                count_next = '0;
                csum_next  = '0;
                rsum_next  = '0;
            end else begin
                count_next = count_upd;
                csum_next  = csum_upd;
                rsum_next  = rsum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            csum_reg  <= '0;
            rsum_reg  <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
            csum_reg  <= csum_next;
            rsum_reg  <= rsum_next;
        end
    end

endmodule

// ===== src/mct_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mct_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mct_pkg::div_ctrl_t            ctrl,
    input  logic [mct_pkg::SUM_W-1:0]     dividend,
    input  logic [mct_pkg::COUNT_W-1:0]   divisor,
    output mct_pkg::div_stat_t            stat,
    output logic [mct_pkg::QW-1:0]        quotient
);

    logic [mct_pkg::SUM_W-1:0]  rem_reg, rem_next;
    logic [mct_pkg::SUM_W-1:0]  den_reg, den_next;
    logic [mct_pkg::QW-1:0]     quo_reg, quo_next;
    logic [mct_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic                       fits;

    always_comb begin
        fits      = rem_reg >= den_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = dividend;
            den_next  = mct_pkg::SUM_W'(divisor) << (mct_pkg::QW - 1);
            step_next = mct_pkg::STEP_W'(mct_pkg::QW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - den_reg;
            end
            quo_next = {quo_reg[mct_pkg::QW-2:0], fits};
            den_next = den_reg >> 1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - mct_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== src/mask_centroid_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_centroid_tracker_top
// foreground centroid, window origin and constant-velocity prediction per frame
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------
//  s_ pixel  | s_valid / s_ready   | s_pixel_label
//  m_ result | m_valid / m_ready   | m_centre_x/y, m_window_x/y, m_predicted_x/y,
//            |                     | m_empty_frame
//  config    | cfg_we              | cfg_index, cfg_data
//
//  pixel words are taken back to back in idle; after the last pixel of a frame
//  s_ready stays low while the shared divider, making one quotient bit a cycle,
//  works first for x then for y; an empty frame skips the divider
//  reset: counters, sums and previous origin cleared, registers to 640/480/96
//  a stalled result stays in the output register while the next frame's pixels
//  are still taken; only that frame's last pixel waits for the register to free
// ----------------------------------------------------------------------------
`include "mask_centroid_tracker_top_macros.svh"

module mask_centroid_tracker_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [mct_pkg::IDX_W-1:0]             cfg_index,
    input  logic [mct_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mct_pkg::LABEL_W-1:0]           s_pixel_label,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mct_pkg::CENTRE_W-1:0]          m_centre_x,
    output logic [mct_pkg::CENTRE_W-1:0]          m_centre_y,
    output logic signed [mct_pkg::WIN_W-1:0]      m_window_x,
    output logic signed [mct_pkg::WIN_W-1:0]      m_window_y,
    output logic signed [mct_pkg::PRED_W-1:0]     m_predicted_x,
    output logic signed [mct_pkg::PRED_W-1:0]     m_predicted_y,
    output logic                                  m_empty_frame
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOADX = 3'd1;
    localparam logic [2:0] ST_WAITX = 3'd2;
    localparam logic [2:0] ST_LOADY = 3'd3;
    localparam logic [2:0] ST_WAITY = 3'd4;
    localparam logic [2:0] ST_POST  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [mct_pkg::CFG_W-1:0] frame_width_reg;
    logic [mct_pkg::CFG_W-1:0] frame_height_reg;
    logic [mct_pkg::CFG_W-1:0] window_size_reg;

    logic [mct_pkg::CFG_W-1:0]  frame_w;
    logic [mct_pkg::CFG_W-1:0]  frame_h;
    logic [mct_pkg::CFG_W-1:0]  win_lim;
    logic [mct_pkg::HALF_W-1:0] half;
    logic                       pix_accept;
    logic                       out_load;

    mct_pkg::acc_out_t  acc_out;
    mct_pkg::div_ctrl_t div_ctrl;
    mct_pkg::div_stat_t div_stat;
    logic [mct_pkg::SUM_W-1:0] div_dividend;
    logic [mct_pkg::QW-1:0]    div_quotient;

    logic [mct_pkg::SUM_W-1:0]         csum_reg;
    logic [mct_pkg::SUM_W-1:0]         rsum_reg;
    logic [mct_pkg::COUNT_W-1:0]       count_reg;
    logic                              empty_reg;
    logic [mct_pkg::HALF_W-1:0]        half_reg;
    logic signed [mct_pkg::WIN_W-1:0]  pre_x_reg;
    logic signed [mct_pkg::WIN_W-1:0]  pre_y_reg;
    logic [mct_pkg::CENTRE_W-1:0]      cx_reg;
    logic [mct_pkg::CENTRE_W-1:0]      cy_reg;

    logic signed [mct_pkg::WIN_W-1:0]  prev_x_reg;
    logic signed [mct_pkg::WIN_W-1:0]  prev_y_reg;
    logic                              started_reg;

    logic signed [mct_pkg::WIN_W-1:0]  start_x;
    logic signed [mct_pkg::WIN_W-1:0]  start_y;
    logic signed [mct_pkg::WIN_W-1:0]  cur_x;
    logic signed [mct_pkg::WIN_W-1:0]  cur_y;
    logic signed [mct_pkg::PRED_XW-1:0] pred_x_wide;
    logic signed [mct_pkg::PRED_XW-1:0] pred_y_wide;

    logic                               m_valid_reg;
    logic [mct_pkg::CENTRE_W-1:0]       m_centre_x_reg;
    logic [mct_pkg::CENTRE_W-1:0]       m_centre_y_reg;
    logic signed [mct_pkg::WIN_W-1:0]   m_window_x_reg;
    logic signed [mct_pkg::WIN_W-1:0]   m_window_y_reg;
    logic signed [mct_pkg::PRED_W-1:0]  m_predicted_x_reg;
    logic signed [mct_pkg::PRED_W-1:0]  m_predicted_y_reg;
    logic                               m_empty_frame_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= mct_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= mct_pkg::RST_FRAME_HEIGHT;
            window_size_reg  <= mct_pkg::RST_WINDOW_SIZE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mct_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                mct_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                mct_pkg::REG_WINDOW_SIZE:  window_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        frame_w = mct_pkg::dim_limit(frame_width_reg, mct_pkg::CFG_XW'(mct_pkg::MAX_WIDTH));
        frame_h = mct_pkg::dim_limit(frame_height_reg, mct_pkg::CFG_XW'(mct_pkg::MAX_HEIGHT));
        win_lim = (mct_pkg::CFG_XW'(window_size_reg) > mct_pkg::CFG_XW'(mct_pkg::WIN_MAX)) ?
                  mct_pkg::CFG_W'(mct_pkg::WIN_MAX) : window_size_reg;
        half    = mct_pkg::HALF_W'(win_lim >> 1);
        start_x = $signed(mct_pkg::WIN_W'(frame_w >> 1)) - $signed(mct_pkg::WIN_W'(half));
        start_y = $signed(mct_pkg::WIN_W'(frame_h >> 1)) - $signed(mct_pkg::WIN_W'(half));
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign pix_accept = s_valid && s_ready;

    mct_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_accept (pix_accept),
        .pix_label  (s_pixel_label),
        .frame_w    (frame_w),
        .frame_h    (frame_h),
        .acc_out    (acc_out)
    );

    assign div_ctrl.start = (state_reg == ST_LOADX) || (state_reg == ST_LOADY);
    assign div_dividend   = (state_reg == ST_LOADX) ? csum_reg : rsum_reg;

    mct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // result arithmetic
    always_comb begin
        if (empty_reg) begin
            cur_x = pre_x_reg;
            cur_y = pre_y_reg;
        end else begin
            cur_x = $signed(mct_pkg::WIN_W'(cx_reg)) - $signed(mct_pkg::WIN_W'(half_reg));
            cur_y = $signed(mct_pkg::WIN_W'(cy_reg)) - $signed(mct_pkg::WIN_W'(half_reg));
        end
        pred_x_wide = (mct_pkg::PRED_XW'(cur_x) <<< 1) - mct_pkg::PRED_XW'(pre_x_reg);
        pred_y_wide = (mct_pkg::PRED_XW'(cur_y) <<< 1) - mct_pkg::PRED_XW'(pre_y_reg);
    end

    assign out_load = (state_reg == ST_POST) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pix_accept && acc_out.frame_end) begin
                    state_next = (acc_out.count == '0) ? ST_POST : ST_LOADX;
                end
            end
            ST_LOADX: state_next = ST_WAITX;
            ST_WAITX: begin
                if (div_stat.done) begin
                    state_next = ST_LOADY;
                end
            end
            ST_LOADY: state_next = ST_WAITY;
            ST_WAITY: begin
                if (div_stat.done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                started_reg <= 1'b1;
                prev_x_reg  <= cur_x;
                prev_y_reg  <= cur_y;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // frame operands and quotients
    always_ff @(posedge aclk) begin
        if (pix_accept && acc_out.frame_end) begin
            csum_reg  <= acc_out.col_sum;
            rsum_reg  <= acc_out.row_sum;
            count_reg <= acc_out.count;
            empty_reg <= (acc_out.count == '0);
            half_reg  <= half;
            pre_x_reg <= started_reg ? prev_x_reg : start_x;
            pre_y_reg <= started_reg ? prev_y_reg : start_y;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        if ((state_reg == ST_WAITX) && div_stat.done) begin
            cx_reg <= mct_pkg::sat_centre(div_quotient);
        end
        if ((state_reg == ST_WAITY) && div_stat.done) begin
            cy_reg <= mct_pkg::sat_centre(div_quotient);
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_centre_x_reg    <= cx_reg;
            m_centre_y_reg    <= cy_reg;
            m_window_x_reg    <= cur_x;
            m_window_y_reg    <= cur_y;
            m_predicted_x_reg <= mct_pkg::sat_pred(pred_x_wide);
            m_predicted_y_reg <= mct_pkg::sat_pred(pred_y_wide);
            m_empty_frame_reg <= empty_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_centre_x    = m_centre_x_reg;
    assign m_centre_y    = m_centre_y_reg;
    assign m_window_x    = m_window_x_reg;
    assign m_window_y    = m_window_y_reg;
    assign m_predicted_x = m_predicted_x_reg;
    assign m_predicted_y = m_predicted_y_reg;
    assign m_empty_frame = m_empty_frame_reg;

    `MCT_ASSERT_IMP(a_div_start_idle, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
    `MCT_ASSERT_IMP(a_div_done_wait, div_stat.done, (state_reg == ST_WAITX) || (state_reg == ST_WAITY), "divider done outside a wait state")
    `MCT_ASSERT_NXT(a_frame_end_busy, pix_accept && acc_out.frame_end, !s_ready, "pixel taken right after frame end")
    `MCT_ASSERT_IMP(a_empty_held, m_valid && m_empty_frame, (m_centre_x == '0) && (m_centre_y == '0) && (m_predicted_x == mct_pkg::PRED_W'(m_window_x)) && (m_predicted_y == mct_pkg::PRED_W'(m_window_y)), "empty frame word does not hold position")

endmodule
